// ----- hdl/bfp_pkg.sv -----
// ----------------------------------------------------------------------------
// bfp_pkg
// Shared types, constants and the CRC-16/MODBUS byte update for the
// battery frame parser.
// ----------------------------------------------------------------------------
package bfp_pkg;

    localparam int          FRAME_BYTES = 18;
    localparam int          POS_W       = 5;
    localparam logic [4:0]  POS_FIRST   = 5'd1;
    localparam logic [4:0]  POS_CRC_LO  = 5'd15;
    localparam logic [4:0]  POS_CRC_HI  = 5'd16;
    localparam logic [4:0]  POS_LAST    = 5'(FRAME_BYTES - 1);

    localparam logic [15:0] CRC_INIT    = 16'hFFFF;
    localparam logic [15:0] CRC_POLY    = 16'hA001;

    localparam logic [7:0]  HEADER_RESET = 8'd123;
    localparam logic [7:0]  TAIL_RESET   = 8'd125;

    localparam int          DATA_W      = 112;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_BAD_TAIL = 2'd1,
        STATUS_BAD_CRC  = 2'd2
    } bfp_status_t;

    typedef enum logic [0:0] {
        CFG_HEADER = 1'b0,
        CFG_TAIL   = 1'b1
    } bfp_cfg_index_t;

    // Reflected CRC-16 update for one byte, LSB first.
    function automatic logic [15:0] crc16_feed(input logic [15:0] crc_in,
                                               input logic [7:0]  data_in);
        logic [15:0] crc;
        crc = crc_in ^ {8'h00, data_in};
        for (int k = 0; k < 8; k++)
        begin
            if (crc[0])
            begin
                crc = (crc >> 1) ^ CRC_POLY;
            end
            else
            begin
                crc = crc >> 1;
            end
        end
        return crc;
    endfunction

endpackage

// ----- hdl/battery_frame_parser_crc16.sv -----
// ----------------------------------------------------------------------------
// battery_frame_parser_crc16
// Header hunt, 18-byte frame capture and CRC-16/MODBUS check for a
// battery monitor byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one received serial byte per beat in s_tdata. Bytes are
//   dropped until one equals the header register; that byte and the next
//   17 form a frame. The CRC runs over frame bytes 0..14, bytes 15/16 must
//   hold its low then high byte, byte 17 must equal the tail register.
//   m_* carries one beat per frame: the status in m_tuser and the decoded
//   fields in m_tdata, whatever the status.
//   Latency: the result beat is valid the cycle after the tail byte beat.
//   Throughput: one byte per clock while s_tready is high; the CRC update and field capture are a
//   single registered stage per byte.
//   Stall: the output register holds one result. s_tready drops only while
//   that result is held and m_tready is low, so bytes keep flowing when
//   the result is taken in the same cycle.
//   Reset: hunting for a header, CRC at 0xFFFF, header 123, tail 125, no
//   result pending. The cfg port writes header (index 0) or tail (index 1)
//   at any edge with cfg_we high.
// ----------------------------------------------------------------------------
module battery_frame_parser_crc16
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  bfp_pkg::bfp_cfg_index_t      cfg_index,
    input  logic [7:0]                   cfg_data,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [7:0]                   s_tdata,   // [7:0] rx_byte
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // [15:0] pack_voltage, [31:16] current_milliamps, [47:32] remaining_charge,
    // [63:48] full_capacity, [71:64] charge_percent, [79:72] control_flags,
    // [95:80] protection_flags, [111:96] cycle_count
    output logic [bfp_pkg::DATA_W-1:0]   m_tdata,
    output bfp_pkg::bfp_status_t         m_tuser    // [1:0] frame_status
);
    import bfp_pkg::*;

    logic [7:0]        header_reg;
    logic [7:0]        tail_reg;
    logic              in_frame_reg, in_frame_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [15:0]       crc_reg, crc_next;
    logic              crc_lo_ok_reg, crc_lo_ok_next;
    logic [7:0]        frame_reg [FRAME_BYTES];
    logic              m_valid_reg, m_valid_next;
    logic [DATA_W-1:0] m_data_reg;
    bfp_status_t       m_status_reg, status_next;

    logic              s_beat;
    logic              frame_done;

    assign s_tready   = !m_valid_reg || m_tready;
    assign s_beat     = s_tvalid && s_tready;
    assign frame_done = s_beat && in_frame_reg && (pos_reg == POS_LAST);

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_status_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_reg <= HEADER_RESET;
            tail_reg   <= TAIL_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_HEADER: header_reg <= cfg_data;
                CFG_TAIL:   tail_reg   <= cfg_data;
                default:    ;
            endcase
        end
    end

    // Frame tracking and CRC
    always_comb
    begin
        in_frame_next  = in_frame_reg;
        pos_next       = pos_reg;
        crc_next       = crc_reg;
        crc_lo_ok_next = crc_lo_ok_reg;
        if (s_beat)
        begin
            if (!in_frame_reg)
            begin
                if (s_tdata == header_reg)
                begin
                    in_frame_next = 1'b1;
                    pos_next      = POS_FIRST;
                    crc_next      = crc16_feed(CRC_INIT, s_tdata);
                end
            end
            else if (pos_reg == POS_LAST || pos_reg > POS_LAST)
            begin
                // close the frame (or recover from an out-of-range position)
                in_frame_next = 1'b0;
                pos_next      = '0;
                crc_next      = CRC_INIT;
            end
            else
            begin
                pos_next = pos_reg + POS_W'(1);
                if (pos_reg < POS_CRC_LO)
                begin
                    crc_next = crc16_feed(crc_reg, s_tdata);
                end
                if (pos_reg == POS_CRC_LO)
                begin
                    crc_lo_ok_next = (s_tdata == crc_reg[7:0]);
                end
            end
        end
    end

    // Status of the frame that ends with this beat
    always_comb
    begin
        if (s_tdata != tail_reg)
        begin
            status_next = STATUS_BAD_TAIL;
        end
        else if (!crc_lo_ok_reg || (frame_reg[POS_CRC_HI] != crc_reg[15:8]))
        begin
            status_next = STATUS_BAD_CRC;
        end
        else
        begin
            status_next = STATUS_OK;
        end
    end

    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
        if (frame_done)
        begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg  <= 1'b0;
            pos_reg       <= '0;
            crc_reg       <= CRC_INIT;
            crc_lo_ok_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            in_frame_reg  <= in_frame_next;
            pos_reg       <= pos_next;
            crc_reg       <= crc_next;
            crc_lo_ok_reg <= crc_lo_ok_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Frame byte store: written at the current position
    always_ff @(posedge clk)
    begin
        if (s_beat && in_frame_reg && pos_reg < POS_LAST)
        begin
            frame_reg[pos_reg] <= s_tdata;
        end
    end

    // Result register: load on the tail byte beat
    always_ff @(posedge clk)
    begin
        if (frame_done)
        begin
            m_status_reg <= status_next;
            m_data_reg   <= {frame_reg[13], frame_reg[14],
                             frame_reg[11], frame_reg[12],
                             frame_reg[10], frame_reg[9],
                             frame_reg[7],  frame_reg[8],
                             frame_reg[5],  frame_reg[6],
                             frame_reg[3],  frame_reg[4],
                             frame_reg[1],  frame_reg[2]};
        end
    end

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_hunt_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !in_frame_reg |-> pos_reg == '0)
        else $error("position not cleared while hunting");

    a_frame_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        in_frame_reg |-> (pos_reg >= POS_FIRST) && (pos_reg <= POS_LAST))
        else $error("frame position out of range");

    a_header_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (s_beat && !in_frame_reg && s_tdata == header_reg)
        |=> (in_frame_reg && pos_reg == POS_FIRST))
        else $error("header beat did not open a frame");

    a_result_from_tail: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_valid_reg) |-> $past(frame_done))
        else $error("result raised without a tail byte beat");

    a_done_closes: assert property (@(posedge clk) disable iff (!rst_n)
        frame_done |=> (!in_frame_reg && m_valid_reg && crc_reg == CRC_INIT))
        else $error("frame end did not reload hunt state");

endmodule

// ----- verif/battery_frame_parser_crc16_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// battery_frame_parser_crc16_tb
// Feeds the parser a byte stream of well-formed, corrupted and truncated
// battery frames mixed with line noise. A behavioral deframer predicts each
// frame result on every accepted byte; result beats are checked field by
// field in order. Both stream sides idle at random, the result side holds
// off for a long stretch once, and header/tail registers change between
// phases after the result stream has drained.
// ----------------------------------------------------------------------------
module battery_frame_parser_crc16_tb;
    import bfp_pkg::*;

    localparam int HALF_PERIOD     = 2;
    localparam int RESET_CYCLES    = 9;
    localparam int STALL_LIMIT     = 2000;
    localparam int LONG_HOLD       = 300;
    localparam int SETTLE_CYCLES   = 4;
    localparam int BYTES_PER_PHASE = 290;
    localparam int NUM_PHASES      = 5;
    localparam int MAX_SHOWN       = 10;

    typedef enum int {
        FILL_RANDOM,
        FILL_ZERO,
        FILL_ONES,
        FILL_HEADER,
        FILL_MAX_POS,
        FILL_MIN_NEG
    } fill_t;

    typedef struct {
        bfp_status_t status;
        logic [15:0] voltage;
        logic [15:0] current_ma;
        logic [15:0] remaining;
        logic [15:0] capacity;
        logic [7:0]  soc;
        logic [7:0]  control;
        logic [15:0] protection;
        logic [15:0] cycles;
    } frame_fields_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_we    = 1'b0;
    bfp_cfg_index_t       cfg_index = CFG_HEADER;
    logic [7:0]           cfg_data  = 8'h00;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata   = 8'h00;   // [7:0] rx_byte
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    // [15:0] pack_voltage, [31:16] current_milliamps, [47:32] remaining_charge,
    // [63:48] full_capacity, [71:64] charge_percent, [79:72] control_flags,
    // [95:80] protection_flags, [111:96] cycle_count
    logic [DATA_W-1:0]    m_tdata;
    bfp_status_t          m_tuser;             // [1:0] frame_status

    // register copies, shared by stimulus and prediction
    logic [7:0]           hdr_reg  = HEADER_RESET;
    logic [7:0]           tail_reg = TAIL_RESET;

    // deframer prediction state
    logic                 mdl_in_frame = 1'b0;
    logic [POS_W-1:0]     mdl_pos      = '0;
    logic [15:0]          mdl_crc      = CRC_INIT;
    logic [7:0]           mdl_bytes [FRAME_BYTES];

    logic [7:0]           rx_stream [$];
    frame_fields_t        frames_due [$];

    logic                 in_taken     = 1'b0;
    int                   src_idle_pct = 26;
    int                   snk_idle_pct = 26;
    int                   hold_asks    = 0;
    int                   hold_done    = 0;
    int                   hold_left    = 0;
    int                   idle_cycles  = 0;
    int                   mismatches   = 0;
    int                   frames_seen  = 0;

    logic [7:0]           hdr_plan  [NUM_PHASES] = '{8'h00, 8'hFF, 8'h55, 8'h00, HEADER_RESET};
    logic [7:0]           tail_plan [NUM_PHASES] = '{8'hFF, 8'h00, 8'h55, 8'h00, TAIL_RESET};

    battery_frame_parser_crc16 DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // Bitwise reflected CRC-16: feed one data bit per shift.
    function automatic logic [15:0] modbus_crc_byte(input logic [15:0] crc_in,
                                                    input logic [7:0]  b);
        logic [15:0] c;
        c = crc_in;
        for (int i = 0; i < 8; i++)
        begin
            if (c[0] ^ b[i])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

    task automatic parse_byte(input logic [7:0] b);
        frame_fields_t r;
        if (!mdl_in_frame)
        begin
            // drop everything but the header while hunting
            if (b == hdr_reg)
            begin
                mdl_bytes[0] = b;
                mdl_crc      = modbus_crc_byte(CRC_INIT, b);
                mdl_pos      = POS_FIRST;
                mdl_in_frame = 1'b1;
            end
        end
        else
        begin
            mdl_bytes[mdl_pos] = b;
            if (mdl_pos < POS_CRC_LO)
                mdl_crc = modbus_crc_byte(mdl_crc, b);
            if (mdl_pos != POS_LAST)
            begin
                mdl_pos = mdl_pos + 1'b1;
            end
            else
            begin
                // tail check wins over the CRC check
                if (mdl_bytes[POS_LAST] != tail_reg)
                    r.status = STATUS_BAD_TAIL;
                else if (mdl_bytes[POS_CRC_LO] != mdl_crc[7:0] ||
                         mdl_bytes[POS_CRC_HI] != mdl_crc[15:8])
                    r.status = STATUS_BAD_CRC;
                else
                    r.status = STATUS_OK;
                r.voltage    = {mdl_bytes[1], mdl_bytes[2]};
                r.current_ma = {mdl_bytes[3], mdl_bytes[4]};
                r.remaining  = {mdl_bytes[5], mdl_bytes[6]};
                r.capacity   = {mdl_bytes[7], mdl_bytes[8]};
                r.soc        = mdl_bytes[9];
                r.control    = mdl_bytes[10];
                r.protection = {mdl_bytes[11], mdl_bytes[12]};
                r.cycles     = {mdl_bytes[13], mdl_bytes[14]};
                frames_due.push_back(r);
                mdl_in_frame = 1'b0;
                mdl_pos      = '0;
                mdl_crc      = CRC_INIT;
            end
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= MAX_SHOWN)
                $display("frame %0d %s: expected %h, got %h", frames_seen, name, want, got);
        end
    endtask

    task automatic push_frame(input bit bad_tail, input bit bad_crc, input fill_t fill);
        logic [7:0]  f [FRAME_BYTES];
        logic [15:0] crc;
        f[0] = hdr_reg;
        crc  = modbus_crc_byte(CRC_INIT, f[0]);
        for (int k = 1; k < POS_CRC_LO; k++)
        begin
            case (fill)
                FILL_ZERO:    f[k] = 8'h00;
                FILL_ONES:    f[k] = 8'hFF;
                FILL_HEADER:  f[k] = hdr_reg;
                FILL_MAX_POS: f[k] = k[0] ? 8'h7F : 8'hFF;
                FILL_MIN_NEG: f[k] = k[0] ? 8'h80 : 8'h00;
                default:      f[k] = 8'($urandom_range(255));
            endcase
            crc = modbus_crc_byte(crc, f[k]);
        end
        f[POS_CRC_LO] = crc[7:0];
        f[POS_CRC_HI] = crc[15:8];
        if (bad_crc)
            f[POS_CRC_LO + $urandom_range(1)] ^= 8'h01 << $urandom_range(7);
        f[POS_LAST] = bad_tail ? tail_reg ^ 8'($urandom_range(1, 255)) : tail_reg;
        foreach (f[k])
            rx_stream.push_back(f[k]);
    endtask

    task automatic push_noise(input int count);
        logic [7:0] b;
        repeat (count)
        begin
            do
                b = 8'($urandom_range(255));
            while (b == hdr_reg);
            rx_stream.push_back(b);
        end
    endtask

    task automatic fill_random(input int target);
        int start;
        int pick;
        start = rx_stream.size();
        while (rx_stream.size() - start < target)
        begin
            pick = $urandom_range(99);
            if (pick < 80)
            begin
                push_noise($urandom_range(0, 2));
                pick = $urandom_range(99);
                push_frame((pick >= 70 && pick < 80) || pick >= 90, pick >= 80,
                           ($urandom_range(19) == 0) ? fill_t'($urandom_range(1, 5))
                                                     : FILL_RANDOM);
            end
            else if (pick < 90)
            begin
                push_noise($urandom_range(1, 6));
            end
            else
            begin
                // truncated frame: the next bytes complete it as data
                rx_stream.push_back(hdr_reg);
                repeat ($urandom_range(1, 16))
                    rx_stream.push_back(8'($urandom_range(255)));
            end
        end
    endtask

    task automatic drain_results();
        while (rx_stream.size() != 0 || s_tvalid || frames_due.size() != 0 || mdl_in_frame)
        begin
            // close an open frame with noise so no frame spans a register write
            if (mdl_in_frame && rx_stream.size() == 0 && !s_tvalid)
                push_noise(1);
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input bfp_cfg_index_t idx, input logic [7:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        if (idx == CFG_HEADER)
            hdr_reg = val;
        else
            tail_reg = val;
    endtask

    // byte source: advance on an accepted beat or when idle
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else if (!s_tvalid || in_taken)
        begin
            if (rx_stream.size() != 0 && $urandom_range(99) >= src_idle_pct)
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= rx_stream.pop_front();
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result sink
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else if (hold_done != hold_asks)
        begin
            hold_done <= hold_done + 1;
            hold_left <= LONG_HOLD;
            m_tready  <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    always @(posedge clk)
    begin : monitor
        frame_fields_t want;
        logic          fire_in;
        logic          fire_out;
        if (rst_n)
        begin
            fire_in  = s_tvalid && s_tready;
            fire_out = m_tvalid && m_tready;
            in_taken <= fire_in;
            if (fire_in)
                parse_byte(s_tdata);
            if (fire_out)
            begin
                if (frames_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display("frame %0d: result beat with none expected", frames_seen);
                end
                else
                begin
                    want = frames_due.pop_front();
                    check_field("status", {14'd0, want.status}, {14'd0, m_tuser});
                    check_field("voltage", want.voltage, m_tdata[15:0]);
                    check_field("current", want.current_ma, m_tdata[31:16]);
                    check_field("remaining", want.remaining, m_tdata[47:32]);
                    check_field("capacity", want.capacity, m_tdata[63:48]);
                    check_field("soc", {8'd0, want.soc}, {8'd0, m_tdata[71:64]});
                    check_field("control", {8'd0, want.control}, {8'd0, m_tdata[79:72]});
                    check_field("protection", want.protection, m_tdata[95:80]);
                    check_field("cycles", want.cycles, m_tdata[111:96]);
                end
                frames_seen++;
            end
            if (fire_in || fire_out)
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles >= STALL_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial
    begin
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        // directed frames at reset register values
        rx_stream.push_back(8'h00);
        rx_stream.push_back(8'hFF);
        push_frame(1'b1, 1'b1, FILL_ZERO);
        push_frame(1'b0, 1'b1, FILL_ONES);
        push_frame(1'b0, 1'b0, FILL_MAX_POS);
        push_frame(1'b1, 1'b0, FILL_MIN_NEG);
        push_frame(1'b0, 1'b0, FILL_HEADER);
        push_frame(1'b0, 1'b0, FILL_RANDOM);
        drain_results();

        hdr_plan[3]  = 8'($urandom_range(255));
        tail_plan[3] = 8'($urandom_range(255));
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            write_reg(CFG_HEADER, hdr_plan[ph]);
            write_reg(CFG_TAIL, tail_plan[ph]);
            src_idle_pct = (ph == 1 || ph == 2) ? 0 : 26;
            snk_idle_pct = (ph == 2) ? 0 : 26;
            // hold the result side while bytes keep coming to back up the input
            if (ph == 1)
                hold_asks++;
            fill_random(BYTES_PER_PHASE);
            drain_results();
        end

        if (mismatches == 0 && frames_due.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
